// ----- sv/calmc_pkg.sv -----
// Shared types and constants of the charge-aware lamp mode controller.
`default_nettype none
package calmc_pkg;

	typedef logic [1:0] mode_t;

	localparam mode_t MODE_OFF    = 2'd0;
	localparam mode_t MODE_ON     = 2'd1;
	localparam mode_t MODE_CHARGE = 2'd2;
	localparam mode_t MODE_FULL   = 2'd3;

	localparam int THR_W = 15;
	localparam int CNT_W = 4;

	localparam logic [THR_W-1:0] CHARGE_THR_RST = 15'd3000;
	localparam logic [THR_W-1:0] FULL_LO_RST    = 15'd200;
	localparam logic [THR_W-1:0] FULL_HI_RST    = 15'd2000;
	localparam logic [THR_W-1:0] UNPLUG_THR_RST = 15'd100;
	localparam logic [CNT_W-1:0] SETTLE_RST     = 4'd10;

	localparam logic [2:0] REG_CHARGE_THR = 3'd0;
	localparam logic [2:0] REG_FULL_LO    = 3'd1;
	localparam logic [2:0] REG_FULL_HI    = 3'd2;
	localparam logic [2:0] REG_UNPLUG_THR = 3'd3;
	localparam logic [2:0] REG_SETTLE     = 3'd4;

	localparam logic [7:0]  BRIGHT_ON    = 8'd255;
	localparam logic [23:0] COLOUR_CHARGE = 24'h0000FF;
	localparam logic [23:0] COLOUR_FULL   = 24'h00FF00;

	typedef struct packed {
		mode_t             lamp;
		mode_t             auto_m;
		logic [CNT_W-1:0]  count;
	} state_t;

	typedef struct packed {
		logic [THR_W-1:0] charge_thr;
		logic [THR_W-1:0] full_lo;
		logic [THR_W-1:0] full_hi;
		logic [THR_W-1:0] unplug_thr;
		logic [CNT_W-1:0] settle;
	} cfg_t;

endpackage
`default_nettype wire

// ----- sv/calmc_step.sv -----
// Next-state and result logic for one request of the lamp mode controller.
`default_nettype none
module calmc_step import calmc_pkg::*; #(
	parameter int CURRENT_BITS = 16
) (
	input  wire logic                    is_sample,
	input  wire logic [CURRENT_BITS-1:0] current,
	input  wire cfg_t                    cfg,
	input  wire state_t                  cur_st,
	output state_t                       nxt_st,
	output logic                         changed
);

	localparam int CMP_W = ((CURRENT_BITS > THR_W) ? CURRENT_BITS : THR_W) + 1;

	logic signed [CMP_W-1:0] cur_x;
	logic signed [CMP_W-1:0] ct_x, fl_x, fh_x, ut_x;
	logic                    is_charge, is_full, is_unplug, have;
	mode_t                   cand, auto_n, lamp_n;
	logic [CNT_W-1:0]        cnt_eff, cnt_n;
	logic                    chg_n;

	assign cur_x = CMP_W'(signed'(current));
	assign ct_x  = CMP_W'(cfg.charge_thr);
	assign fl_x  = CMP_W'(cfg.full_lo);
	assign fh_x  = CMP_W'(cfg.full_hi);
	assign ut_x  = CMP_W'(cfg.unplug_thr);

	assign is_charge = cur_x > ct_x;
	assign is_full   = (cur_x > fl_x) && (cur_x < fh_x);
	assign is_unplug = cur_x < ut_x;
	assign have      = is_charge || is_full;
	assign cand      = is_charge ? MODE_CHARGE : MODE_FULL;
	assign cnt_eff   = (is_charge && cur_st.auto_m == MODE_OFF) ? cfg.settle : cur_st.count;

	always_comb begin
		auto_n = cur_st.auto_m;
		cnt_n  = cur_st.count;
		lamp_n = cur_st.lamp;
		chg_n  = 1'b0;
		if (!is_sample) begin
			chg_n = 1'b1;
			if (cur_st.lamp == MODE_OFF) begin
				lamp_n = MODE_ON;
			end else if (cur_st.lamp == MODE_ON && cur_st.auto_m != MODE_OFF) begin
				lamp_n = cur_st.auto_m;
			end else begin
				lamp_n = MODE_OFF;
			end
		end else begin
			if (have) begin
				if (cand != cur_st.auto_m && cnt_eff < cfg.settle) begin
					cnt_n = cnt_eff + 1'b1;
				end else begin
					auto_n = cand;
					cnt_n  = '0;
				end
			end else if (is_unplug) begin
				auto_n = MODE_OFF;
			end
			if (auto_n != cur_st.auto_m &&
			    (cur_st.auto_m == cur_st.lamp || auto_n == MODE_OFF)) begin
				lamp_n = auto_n;
				chg_n  = 1'b1;
			end
		end
	end

	assign nxt_st.lamp   = lamp_n;
	assign nxt_st.auto_m = auto_n;
	assign nxt_st.count  = cnt_n;
	assign changed       = chg_n;

endmodule
`default_nettype wire

// ----- sv/charge_aware_lamp_mode_controller.sv -----
// Top level of the charge-aware lamp mode controller: registers, APB port, pipeline.
//
//  channel  | handshake                  | payload
//  item     | item_valid / item_stall    | req_type, current_tenth_ma
//  result   | result_valid / result_stall| lamp_mode, auto_mode, mode_changed,
//           |                            | brightness, fill_color
//  config   | APB psel/penable/pwrite    | paddr, pwdata, prdata
//
// One request per cycle while item_stall is low; each request passes from acceptance
// through the input register, then through the mode logic into the result register.
// Mode state updates as a request leaves the input register.
// arst_n clears state, registers to their defaults and both pipeline stages.
// A stalled result holds the result register and, once the input register is full,
// stalls the item channel.
`default_nettype none
module charge_aware_lamp_mode_controller import calmc_pkg::*; #(
	parameter int CURRENT_BITS = 16
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    item_valid,
	output logic                         item_stall,
	input  wire logic                    req_type,
	input  wire logic [CURRENT_BITS-1:0] current_tenth_ma,
	output logic                         result_valid,
	input  wire logic                    result_stall,
	output mode_t                        lamp_mode,
	output mode_t                        auto_mode,
	output logic                         mode_changed,
	output logic [7:0]                   brightness,
	output logic [23:0]                  fill_color,
	input  wire logic                    psel,
	input  wire logic                    penable,
	input  wire logic                    pwrite,
	input  wire logic [4:0]              paddr,
	input  wire logic [31:0]             pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	cfg_t   cfg_q;
	state_t st_q, st_n;
	logic   chg_n;

	logic                    valid_s1;
	logic                    type_s1;
	logic [CURRENT_BITS-1:0] cur_s1;
	logic                    valid_s2;
	logic                    adv_s1, take_in;
	logic                    wr_en;
	logic [2:0]              reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.charge_thr <= CHARGE_THR_RST;
			cfg_q.full_lo    <= FULL_LO_RST;
			cfg_q.full_hi    <= FULL_HI_RST;
			cfg_q.unplug_thr <= UNPLUG_THR_RST;
			cfg_q.settle     <= SETTLE_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_CHARGE_THR: cfg_q.charge_thr <= pwdata[THR_W-1:0];
				REG_FULL_LO:    cfg_q.full_lo    <= pwdata[THR_W-1:0];
				REG_FULL_HI:    cfg_q.full_hi    <= pwdata[THR_W-1:0];
				REG_UNPLUG_THR: cfg_q.unplug_thr <= pwdata[THR_W-1:0];
				REG_SETTLE:     cfg_q.settle     <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_CHARGE_THR: prdata = 32'(cfg_q.charge_thr);
			REG_FULL_LO:    prdata = 32'(cfg_q.full_lo);
			REG_FULL_HI:    prdata = 32'(cfg_q.full_hi);
			REG_UNPLUG_THR: prdata = 32'(cfg_q.unplug_thr);
			REG_SETTLE:     prdata = 32'(cfg_q.settle);
			default:        prdata = '0;
		endcase
	end

	// advance stage 1 when the result register is free or being drained
	assign adv_s1     = valid_s1 && (!valid_s2 || !result_stall);
	assign item_stall = valid_s1 && !adv_s1;
	assign take_in    = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			type_s1 <= req_type;
			cur_s1  <= current_tenth_ma;
		end
	end

	calmc_step #(
		.CURRENT_BITS(CURRENT_BITS)
	) u_step (
		.is_sample (type_s1),
		.current   (cur_s1),
		.cfg       (cfg_q),
		.cur_st    (st_q),
		.nxt_st    (st_n),
		.changed   (chg_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.lamp   <= MODE_OFF;
			st_q.auto_m <= MODE_OFF;
			st_q.count  <= '0;
			valid_s2    <= 1'b0;
		end else begin
			if (adv_s1) begin
				st_q     <= st_n;
				valid_s2 <= 1'b1;
			end else if (!result_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			lamp_mode    <= st_n.lamp;
			auto_mode    <= st_n.auto_m;
			mode_changed <= chg_n;
			brightness   <= (st_n.lamp == MODE_OFF) ? 8'd0 : BRIGHT_ON;
			case (st_n.lamp)
				MODE_CHARGE: fill_color <= COLOUR_CHARGE;
				MODE_FULL:   fill_color <= COLOUR_FULL;
				default:     fill_color <= '0;
			endcase
		end
	end

	assign result_valid = valid_s2;

endmodule
`default_nettype wire
